@@ sv/rpnm_pkg.sv @@
// ----------------------------------------------------------------------------
// rpnm_pkg
// Types and codes shared by the raw image header checker and its parts.
// ----------------------------------------------------------------------------
package rpnm_pkg;

   // Result kinds.
   localparam logic KIND_PIXEL   = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // Verdict status codes.
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD      = 2'd1;
   localparam logic [1:0] ST_MISMATCH = 2'd2;

   // Shortest file, in bytes, that can earn a verdict other than bad.
   localparam logic [3:0] MIN_FILE_LEN = 4'd11;
   localparam logic [7:0] MAX_LEVEL_LIMIT = 8'd255;

   typedef struct packed {
      logic        kind;
      logic [7:0]  pixel_value;
      logic [1:0]  channel;
      logic        is_color;
      logic [15:0] width;
      logic [15:0] height;
      logic [7:0]  max_level;
      logic [1:0]  status;
      logic        last;
   } rpnm_result_type;

   // Up to two result words produced by one accepted byte, in order.
   typedef struct packed {
      logic [1:0]      count;
      rpnm_result_type first;
      rpnm_result_type second;
   } rpnm_push_type;

endpackage

@@ sv/rpnm_parser.sv @@
// ----------------------------------------------------------------------------
// rpnm_parser
// Header state machine, number accumulation and pixel counting, one byte per
// accepted word; emits up to two result words for that byte.
// ----------------------------------------------------------------------------
module rpnm_parser #(
   parameter int DIM_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_accept,
   input  logic [7:0]              in_byte,
   input  logic                    in_eof,
   output rpnm_pkg::rpnm_push_type push
);
   import rpnm_pkg::*;

   localparam int AccW = DIM_BITS + 4;

   localparam logic [3:0] PH_MAGIC_P = 4'd0;
   localparam logic [3:0] PH_MAGIC_D = 4'd1;
   localparam logic [3:0] PH_WS_W    = 4'd2;
   localparam logic [3:0] PH_NUM_W   = 4'd3;
   localparam logic [3:0] PH_WS_H    = 4'd4;
   localparam logic [3:0] PH_NUM_H   = 4'd5;
   localparam logic [3:0] PH_WS_M    = 4'd6;
   localparam logic [3:0] PH_NUM_M   = 4'd7;
   localparam logic [3:0] PH_PIXELS  = 4'd8;

   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_5     = 8'h35;
   localparam logic [7:0] CH_6     = 8'h36;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;

   logic [3:0]          phase_ff, phase_in;
   logic [DIM_BITS-1:0] acc_ff, acc_in;
   logic [DIM_BITS-1:0] width_ff, width_in;
   logic [DIM_BITS-1:0] height_ff, height_in;
   logic [7:0]          max_ff, max_in;
   logic                color_ff, color_in;
   logic                err_ff, err_in;
   logic [3:0]          len_ff, len_in;
   logic [1:0]          ch_ff, ch_in;
   logic [DIM_BITS-1:0] col_ff, col_in;
   logic [DIM_BITS:0]   row_ff, row_in;

   always_comb begin
      logic            is_dig;
      logic            is_sp;
      logic [3:0]      digit;
      logic [AccW-1:0] prod;
      logic [1:0]      chans;
      logic [1:0]      ch_inc;
      logic [DIM_BITS-1:0] col_inc;
      logic            pix;
      rpnm_result_type verdict;
      rpnm_result_type pixel_res;

      phase_in  = phase_ff;
      acc_in    = acc_ff;
      width_in  = width_ff;
      height_in = height_ff;
      max_in    = max_ff;
      color_in  = color_ff;
      err_in    = err_ff;
      len_in    = len_ff;
      ch_in     = ch_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      pix       = 1'b0;
      push      = '0;

      is_dig = (in_byte >= CH_0) && (in_byte <= CH_9);
      is_sp  = (in_byte == CH_SPACE) || (in_byte == CH_TAB) ||
               (in_byte == CH_LF) || (in_byte == CH_CR);
      digit  = 4'(in_byte - CH_0);
      // acc * 10 + digit, with four spare bits to see an overflow.
      prod   = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1) + AccW'(digit);
      chans  = color_ff ? 2'd3 : 2'd1;
      ch_inc = ch_ff + 2'd1;
      col_inc = col_ff + 1'b1;

      pixel_res = '0;
      pixel_res.kind        = KIND_PIXEL;
      pixel_res.pixel_value = in_byte;
      pixel_res.channel     = ch_ff;
      pixel_res.is_color    = color_ff;

      verdict = '0;
      verdict.kind = KIND_VERDICT;
      verdict.last = 1'b1;

      if (in_accept) begin
         if (len_ff < MIN_FILE_LEN) begin
            len_in = len_ff + 4'd1;
         end
         if (!err_ff) begin
            case (phase_ff)
               PH_MAGIC_P: begin
                  if (in_byte == CH_P) phase_in = PH_MAGIC_D;
                  else err_in = 1'b1;
               end
               PH_MAGIC_D: begin
                  if (in_byte == CH_5 || in_byte == CH_6) begin
                     color_in = (in_byte == CH_6);
                     phase_in = PH_WS_W;
                  end else begin
                     err_in = 1'b1;
                  end
               end
               PH_WS_W, PH_WS_H, PH_WS_M: begin
                  if (is_dig) begin
                     acc_in   = DIM_BITS'(digit);
                     phase_in = phase_ff + 4'd1;
                  end else if (!is_sp) begin
                     err_in = 1'b1;
                  end
               end
               PH_NUM_W, PH_NUM_H: begin
                  if (is_dig) begin
                     acc_in = prod[DIM_BITS-1:0];
                     if (|prod[AccW-1:DIM_BITS]) err_in = 1'b1;
                  end else begin
                     if (phase_ff == PH_NUM_W) width_in = acc_ff;
                     else height_in = acc_ff;
                     if (is_sp) phase_in = phase_ff + 4'd1;
                     else err_in = 1'b1;
                  end
               end
               PH_NUM_M: begin
                  if (is_dig) begin
                     acc_in = prod[DIM_BITS-1:0];
                     if (|prod[AccW-1:DIM_BITS]) err_in = 1'b1;
                  end else if (width_ff == '0 || height_ff == '0 || acc_ff == '0 ||
                               acc_ff > DIM_BITS'(MAX_LEVEL_LIMIT)) begin
                     err_in = 1'b1;
                  end else begin
                     // The terminating byte is swallowed here, whatever it is.
                     max_in   = 8'(acc_ff);
                     ch_in    = 2'd0;
                     col_in   = '0;
                     row_in   = '0;
                     phase_in = PH_PIXELS;
                  end
               end
               default: begin
                  pix = 1'b1;
                  if (row_ff >= {1'b0, height_ff}) begin
                     // Past the frame: hold the row count one beyond height.
                     row_in = {1'b0, height_ff} + 1'b1;
                  end else if (ch_inc >= chans) begin
                     ch_in = 2'd0;
                     if (col_inc >= width_ff) begin
                        col_in = '0;
                        row_in = row_ff + 1'b1;
                     end else begin
                        col_in = col_inc;
                     end
                  end else begin
                     ch_in = ch_inc;
                  end
               end
            endcase
         end

         if (err_in || phase_in != PH_PIXELS || len_in < MIN_FILE_LEN) begin
            verdict.status = ST_BAD;
         end else begin
            verdict.is_color  = color_in;
            verdict.width     = 16'(width_in);
            verdict.height    = 16'(height_in);
            verdict.max_level = max_in;
            verdict.status    = (row_in == {1'b0, height_in} && col_in == '0 &&
                                 ch_in == 2'd0) ? ST_OK : ST_MISMATCH;
         end

         if (pix) begin
            push.first = pixel_res;
            if (in_eof) begin
               push.second = verdict;
               push.count  = 2'd2;
            end else begin
               push.count = 2'd1;
            end
         end else if (in_eof) begin
            push.first = verdict;
            push.count = 2'd1;
         end

         // The final byte leaves the parser ready for the next file.
         if (in_eof) begin
            phase_in  = PH_MAGIC_P;
            acc_in    = '0;
            width_in  = '0;
            height_in = '0;
            max_in    = '0;
            color_in  = 1'b0;
            err_in    = 1'b0;
            len_in    = '0;
            ch_in     = '0;
            col_in    = '0;
            row_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_MAGIC_P;
         acc_ff    <= '0;
         width_ff  <= '0;
         height_ff <= '0;
         max_ff    <= '0;
         color_ff  <= 1'b0;
         err_ff    <= 1'b0;
         len_ff    <= '0;
         ch_ff     <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         acc_ff    <= acc_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         max_ff    <= max_in;
         color_ff  <= color_in;
         err_ff    <= err_in;
         len_ff    <= len_in;
         ch_ff     <= ch_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

endmodule

@@ sv/rpnm_out_queue.sv @@
// ----------------------------------------------------------------------------
// rpnm_out_queue
// Three-word result register file: up to two words a cycle in from the parser
// while in_ready, one word a cycle out to the result channel while out_ready.
// ----------------------------------------------------------------------------
module rpnm_out_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  rpnm_pkg::rpnm_push_type   push,
   output logic                      in_ready,
   output logic                      out_valid,
   output rpnm_pkg::rpnm_result_type out_word,
   input  logic                      out_ready
);
   import rpnm_pkg::*;

   function automatic logic [1:0] ptr_inc(input logic [1:0] p);
      return (p == 2'd2) ? 2'd0 : p + 2'd1;
   endfunction

   rpnm_result_type ent_ff [3];
   logic [1:0] wptr_ff, wptr_in;
   logic [1:0] rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       pop;

   assign out_valid = (cnt_ff != 2'd0);
   assign out_word  = ent_ff[rptr_ff];
   // Room for two more words is always kept while input is taken.
   assign in_ready  = (cnt_ff <= 2'd1);
   assign pop       = out_valid && out_ready;

   always_comb begin
      logic [2:0] sum;
      sum     = {1'b0, cnt_ff} + {1'b0, push.count} - {2'b0, pop};
      cnt_in  = sum[1:0];
      rptr_in = pop ? ptr_inc(rptr_ff) : rptr_ff;
      case (push.count)
         2'd1:    wptr_in = ptr_inc(wptr_ff);
         2'd2:    wptr_in = ptr_inc(ptr_inc(wptr_ff));
         default: wptr_in = wptr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         ent_ff[wptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         ent_ff[ptr_inc(wptr_ff)] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

@@ sv/raw_pnm_header_check.sv @@
// ----------------------------------------------------------------------------
// raw_pnm_header_check
// A result word is written into the output queue when its byte is accepted and
// is offered from there in order. One byte is taken per cycle while the queue
// has room; a final pixel byte yields two words, the pixel then the verdict,
// and the byte after it waits while the queue drains.
// Reset clears the parser state and empties the output queue.
// ----------------------------------------------------------------------------
module raw_pnm_header_check #(
   parameter int DIM_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tlast,   // end_of_file
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // pixel_value, channel, is_color, width, height, max_level, status, pad
   output logic [55:0] rsp_tdata,
   output logic        rsp_tuser,   // kind
   output logic        rsp_tlast    // last
);
   import rpnm_pkg::*;

   logic            req_accept;
   rpnm_push_type   push;
   rpnm_result_type word;

   assign req_accept = req_tvalid && req_tready;

   rpnm_parser #(
      .DIM_BITS(DIM_BITS)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .in_accept(req_accept),
      .in_byte  (req_tdata),
      .in_eof   (req_tlast),
      .push     (push)
   );

   rpnm_out_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .in_ready (req_tready),
      .out_valid(rsp_tvalid),
      .out_word (word),
      .out_ready(rsp_tready)
   );

   assign rsp_tdata = {3'b000, word.status, word.max_level, word.height, word.width,
                       word.is_color, word.channel, word.pixel_value};
   assign rsp_tuser = word.kind;
   assign rsp_tlast = word.last;

   // Only the verdict word closes a file.
   a_last_is_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == KIND_VERDICT)))
      else $error("last flag disagrees with word kind");

   // A bad-header verdict carries no parsed dimensions.
   a_bad_zero_dims: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_VERDICT && rsp_tdata[52:51] == ST_BAD)
      |-> (rsp_tdata[50:11] == '0))
      else $error("bad-header verdict with nonzero fields");

   // Two words come only from an accepted final byte.
   a_two_on_eof: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |-> (req_accept && req_tlast))
      else $error("two result words without end of file");

   // The queue is empty and ready right after reset.
   a_ready_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (req_tready && !rsp_tvalid))
      else $error("queue not empty after reset");

endmodule
